>>> hw/rtl/abkf_pkg.sv
// ---------------------------------------------------------------------------
// abkf_pkg
// Shared types and constants of the angle / gyro-bias Kalman filter.
// ---------------------------------------------------------------------------
package abkf_pkg;

    // noise register width and reset values
    localparam int          NOISE_W       = 47;
    localparam logic [46:0] PNA_RESET     = 47'd85899;
    localparam logic [46:0] PNB_RESET     = 47'd429496730;
    localparam logic [46:0] MN_RESET      = 47'd1288490189;

    // register indexes on the configuration port
    localparam logic [1:0]  REG_PNA       = 2'd0;
    localparam logic [1:0]  REG_PNB       = 2'd1;
    localparam logic [1:0]  REG_MN        = 2'd2;

    // operation codes of an input word
    localparam logic        OP_PREDICT    = 1'b0;
    localparam logic        OP_UPDATE     = 1'b1;

    // status of a multi-cycle arithmetic unit
    typedef struct packed {
        logic done;
        logic sat;
    } t_unit_stat;

    // sequencer of the back end
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
        ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6, ST_U7, ST_U8,
        ST_OUT
    } t_seq_state;

    typedef enum logic [2:0] {
        MS_IDLE, MS_ABS, MS_PROD, MS_ACC, MS_FIN
    } t_mul_state;

    typedef enum logic [1:0] {
        DS_IDLE, DS_ABS, DS_RUN, DS_FIN
    } t_div_state;

endpackage

>>> hw/rtl/abkf_mul.sv
// ---------------------------------------------------------------------------
// abkf_mul
// Saturating fixed-point multiplier, 16-bit digit of one operand per round.
// ---------------------------------------------------------------------------
module abkf_mul import abkf_pkg::*; #(
    parameter int DW   = 48,
    parameter int FRAC = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_a,
    input  logic signed [DW-1:0] i_b,
    output logic signed [DW-1:0] o_result,
    output t_unit_stat           o_stat
);

    localparam int CW   = 16;
    localparam int NCH  = (DW + CW - 1) / CW;
    localparam int MW   = NCH * CW;
    localparam int PW   = DW + MW;
    localparam int QW   = PW - FRAC;
    localparam int IW   = $clog2(NCH);
    localparam int CMPW = ((QW > DW) ? QW : DW) + 1;

    t_mul_state           r_state, n_state;
    logic signed [DW-1:0] r_a, r_b;
    logic [DW-1:0]        r_ma;
    logic [MW-1:0]        r_mb;
    logic                 r_neg;
    logic [DW+CW-1:0]     r_pp;
    logic [PW-1:0]        r_acc;
    logic [IW-1:0]        r_idx;
    logic [CMPW-1:0]      w_q, w_lim, w_mv;
    logic                 w_sat;

    // next state, a new product may start in the finishing cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MS_IDLE: if (i_start) n_state = MS_ABS;
            MS_ABS:  n_state = MS_PROD;
            MS_PROD: n_state = MS_ACC;
            MS_ACC:  n_state = (r_idx == IW'(NCH - 1)) ? MS_FIN : MS_PROD;
            MS_FIN:  n_state = i_start ? MS_ABS : MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            MS_IDLE, MS_FIN: begin
                if (i_start) begin
                    r_a <= i_a;
                    r_b <= i_b;
                end
            end
            MS_ABS: begin
                r_ma  <= r_a[DW-1] ? DW'(-r_a) : DW'(r_a);
                r_mb  <= r_b[DW-1] ? MW'(DW'(-r_b)) : MW'(DW'(r_b));
                r_neg <= r_a[DW-1] ^ r_b[DW-1];
                r_acc <= '0;
                r_idx <= '0;
            end
            MS_PROD: begin
                r_pp <= (DW+CW)'(r_ma) * (DW+CW)'(r_mb[CW-1:0]);
            end
            MS_ACC: begin
                r_acc <= r_acc + (PW'(r_pp) << (r_idx * CW));
                r_mb  <= r_mb >> CW;
                r_idx <= r_idx + IW'(1);
            end
            default: ;
        endcase
    end

    // truncate the fraction and saturate
    always_comb begin
        w_q      = CMPW'(r_acc[PW-1:FRAC]);
        w_lim    = CMPW'({(DW-1){1'b1}}) + CMPW'(r_neg);
        w_sat    = w_q > w_lim;
        w_mv     = w_sat ? w_lim : w_q;
        o_result = r_neg ? DW'(CMPW'(0) - w_mv) : DW'(w_mv);
    end

    // outputs
    always_comb begin
        o_stat.done = (r_state == MS_FIN);
        o_stat.sat  = w_sat;
    end

endmodule

>>> hw/rtl/abkf_div.sv
// ---------------------------------------------------------------------------
// abkf_div
// Saturating fixed-point divider, restoring, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module abkf_div import abkf_pkg::*; #(
    parameter int DW   = 48,
    parameter int FRAC = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [DW-1:0] o_result,
    output t_unit_stat           o_stat
);

    localparam int DQ   = DW + FRAC;
    localparam int CTW  = $clog2(DQ);
    localparam int CMPW = DQ + 1;

    t_div_state           r_state, n_state;
    logic signed [DW-1:0] r_num, r_den;
    logic [DW-1:0]        r_d, r_rem;
    logic [DQ-1:0]        r_dvd, r_q;
    logic [CTW-1:0]       r_cnt;
    logic                 r_zero, r_npos, r_nneg, r_neg;
    logic [DW:0]          w_rr;
    logic                 w_ge;
    logic [CMPW-1:0]      w_q, w_lim, w_mv;
    logic                 w_sat;

    // next state, a new quotient may start in the finishing cycle
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DS_IDLE: if (i_start) n_state = DS_ABS;
            DS_ABS:  n_state = (r_den == '0) ? DS_FIN : DS_RUN;
            DS_RUN:  if (r_cnt == CTW'(DQ - 1)) n_state = DS_FIN;
            DS_FIN:  n_state = i_start ? DS_ABS : DS_IDLE;
            default: n_state = DS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one trial subtraction
    always_comb begin
        w_rr = {r_rem, r_dvd[DQ-1]};
        w_ge = w_rr >= {1'b0, r_d};
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            DS_IDLE, DS_FIN: begin
                if (i_start) begin
                    r_num <= i_num;
                    r_den <= i_den;
                end
            end
            DS_ABS: begin
                r_zero <= (r_den == '0);
                r_npos <= !r_num[DW-1] && (r_num != '0);
                r_nneg <= r_num[DW-1];
                r_neg  <= r_num[DW-1] ^ r_den[DW-1];
                r_d    <= r_den[DW-1] ? DW'(-r_den) : DW'(r_den);
                r_dvd  <= DQ'(r_num[DW-1] ? DW'(-r_num) : DW'(r_num)) << FRAC;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
            end
            DS_RUN: begin
                r_rem <= w_ge ? DW'(w_rr - {1'b0, r_d}) : DW'(w_rr);
                r_q   <= {r_q[DQ-2:0], w_ge};
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + CTW'(1);
            end
            default: ;
        endcase
    end

    // saturate, zero divisor goes to the extreme of the numerator's sign (zero for a zero numerator)
    always_comb begin
        w_q   = CMPW'(r_q);
        w_lim = CMPW'({(DW-1){1'b1}}) + CMPW'(r_neg);
        w_sat = w_q > w_lim;
        w_mv  = w_sat ? w_lim : w_q;
        if (r_zero) begin
            o_result = r_npos ? {1'b0, {(DW-1){1'b1}}} :
                       r_nneg ? {1'b1, {(DW-1){1'b0}}} : '0;
        end else begin
            o_result = r_neg ? DW'(CMPW'(0) - w_mv) : DW'(w_mv);
        end
    end

    // outputs
    always_comb begin
        o_stat.done = (r_state == DS_FIN);
        o_stat.sat  = r_zero ? (r_npos || r_nneg) : w_sat;
    end

endmodule

>>> hw/rtl/abkf_front.sv
// ---------------------------------------------------------------------------
// abkf_front
// Input side: takes words and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module abkf_front import abkf_pkg::*; #(
    parameter int DW = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_operation,
    input  logic signed [DW-1:0] i_gyro_rate,
    input  logic [31:0]          i_time_step,
    input  logic signed [DW-1:0] i_measured_angle,
    output logic                 o_q_valid,
    input  logic                 i_pop,
    output logic                 o_q_update,
    output logic signed [DW-1:0] o_q_rate,
    output logic [31:0]          o_q_tstep,
    output logic signed [DW-1:0] o_q_meas
);

    localparam int EW = 1 + DW + 32 + DW;

    logic [EW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;
    logic [EW-1:0] w_head;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign w_push    = i_valid && !o_stall;
    assign w_pop     = i_pop && o_q_valid;

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // queue storage, operation classified into its flag
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= {i_operation == OP_UPDATE, i_gyro_rate, i_time_step,
                            i_measured_angle};
        end
    end

    assign w_head = r_mem[r_rp];
    assign o_q_update = w_head[EW-1];
    assign o_q_rate   = w_head[EW-2 -: DW];
    assign o_q_tstep  = w_head[DW+31 -: 32];
    assign o_q_meas   = w_head[DW-1:0];

endmodule

>>> hw/rtl/abkf_back.sv
// ---------------------------------------------------------------------------
// abkf_back
// Execution side: filter state, step sequencer, shared units, result register.
// ---------------------------------------------------------------------------
module abkf_back import abkf_pkg::*; #(
    parameter int DW   = 48,
    parameter int FRAC = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  logic                 i_q_update,
    input  logic signed [DW-1:0] i_q_rate,
    input  logic [31:0]          i_q_tstep,
    input  logic signed [DW-1:0] i_q_meas,
    input  logic [NOISE_W-1:0]   i_pna,
    input  logic [NOISE_W-1:0]   i_pnb,
    input  logic [NOISE_W-1:0]   i_mn,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [DW-1:0] o_angle_estimate,
    output logic signed [DW-1:0] o_bias_estimate,
    output logic                 o_saturated
);

    localparam int EW = ((DW > NOISE_W) ? DW : NOISE_W) + 2;
    localparam logic [DW-1:0]        MAXV = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [EW-1:0] MAXE = EW'(MAXV);
    localparam logic signed [EW-1:0] MINE = -MAXE - EW'(1);

    // saturating add or subtract, returns {sat, value}
    function automatic logic [DW:0] f_sat(input logic signed [EW-1:0] a,
                                          input logic signed [EW-1:0] b,
                                          input logic do_sub);
        logic signed [EW-1:0] s;
        logic [DW:0]          r;
        s = do_sub ? a - b : a + b;
        if (s > MAXE) r = {1'b1, MAXV};
        else if (s < MINE) r = {1'b1, ~MAXV};
        else r = {1'b0, s[DW-1:0]};
        return r;
    endfunction

    t_seq_state           r_state, n_state;
    logic signed [DW-1:0] r_angle, r_bias, r_c00, r_c01, r_c10, r_c11;
    logic signed [DW-1:0] r_rate, r_meas, r_dt, r_t, r_u, r_s, r_y, r_k0, r_k1;
    logic [31:0]          r_ts;
    logic                 r_sat;
    logic                 r_ovalid;
    logic signed [DW-1:0] r_oang, r_obias;
    logic                 r_osat;

    logic                 w_mstart, w_dstart;
    logic signed [DW-1:0] w_ma, w_mb, w_dnum, w_dden;
    logic signed [DW-1:0] w_mres, w_dres;
    t_unit_stat           w_mstat, w_dstat;
    logic                 w_can_out;

    logic [71:0]          w_tsw;
    logic [DW:0]          w_dt, w_opd, w_sum, w_s, w_y, w_ang, w_bia, w_t, w_u;
    logic [DW:0]          w_c01, w_c10, w_c11, w_n00, w_n11, w_u01;

    abkf_mul #(.DW(DW), .FRAC(FRAC)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mstart),
        .i_a      (w_ma),
        .i_b      (w_mb),
        .o_result (w_mres),
        .o_stat   (w_mstat)
    );

    abkf_div #(.DW(DW), .FRAC(FRAC)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_dstart),
        .i_num    (w_dnum),
        .i_den    (w_dden),
        .o_result (w_dres),
        .o_stat   (w_dstat)
    );

    // short arithmetic around the shared units
    always_comb begin
        w_tsw = (72'(r_ts) << FRAC) >> 32;
        w_dt  = (w_tsw > 72'(MAXV)) ? {1'b1, MAXV} : {1'b0, w_tsw[DW-1:0]};
        w_opd = f_sat(EW'(r_rate), EW'(r_bias), 1'b1);
        w_sum = f_sat(EW'(r_c10), EW'(r_c01), 1'b0);
        w_s   = f_sat(EW'(r_c00), EW'(i_mn), 1'b0);
        w_y   = f_sat(EW'(r_meas), EW'(r_angle), 1'b1);
        w_ang = f_sat(EW'(r_angle), EW'(w_mres), 1'b0);
        w_bia = f_sat(EW'(r_bias), EW'(w_mres), 1'b0);
        w_t   = f_sat(EW'(r_c00), EW'(w_mres), 1'b1);
        w_u   = f_sat(EW'(r_t), EW'(w_mres), 1'b0);
        w_u01 = f_sat(EW'(r_c01), EW'(w_mres), 1'b1);
        w_c01 = w_u01;
        w_c10 = f_sat(EW'(r_c10), EW'(w_mres), 1'b1);
        w_c11 = f_sat(EW'(r_c11), EW'(w_mres), 1'b1);
        w_n00 = f_sat(EW'(r_u), EW'(i_pna), 1'b0);
        w_n11 = f_sat(EW'(r_c11), EW'(i_pnb), 1'b0);
    end

    assign w_can_out = !r_ovalid || !i_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = i_q_update ? ST_U0 : ST_P0;
            ST_P0:   n_state = ST_P1;
            ST_P1:   if (w_mstat.done) n_state = ST_P2;
            ST_P2:   if (w_mstat.done) n_state = ST_P3;
            ST_P3:   if (w_mstat.done) n_state = ST_P4;
            ST_P4:   if (w_mstat.done) n_state = ST_P5;
            ST_P5:   if (w_mstat.done) n_state = ST_OUT;
            ST_U0:   n_state = ST_U1;
            ST_U1:   if (w_dstat.done) n_state = ST_U2;
            ST_U2:   if (w_dstat.done) n_state = ST_U3;
            ST_U3:   if (w_mstat.done) n_state = ST_U4;
            ST_U4:   if (w_mstat.done) n_state = ST_U5;
            ST_U5:   if (w_mstat.done) n_state = ST_U6;
            ST_U6:   if (w_mstat.done) n_state = ST_U7;
            ST_U7:   if (w_mstat.done) n_state = ST_U8;
            ST_U8:   if (w_mstat.done) n_state = ST_OUT;
            ST_OUT:  if (w_can_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // unit launches and operand selection
    always_comb begin
        o_q_pop  = 1'b0;
        w_mstart = 1'b0;
        w_dstart = 1'b0;
        w_ma     = r_dt;
        w_mb     = r_c11;
        w_dnum   = r_c00;
        w_dden   = r_s;
        unique case (r_state)
            ST_IDLE: o_q_pop = i_q_valid;
            ST_P0: begin
                w_mstart = 1'b1;
                w_ma     = w_dt[DW-1:0];
                w_mb     = w_opd[DW-1:0];
            end
            ST_P1: begin
                w_mstart = w_mstat.done;
                w_mb     = w_sum[DW-1:0];
            end
            ST_P2: begin
                w_mstart = w_mstat.done;
                w_mb     = r_dt;
            end
            ST_P3: begin
                w_mstart = w_mstat.done;
                w_ma     = w_mres;
            end
            ST_P4: w_mstart = w_mstat.done;
            ST_U0: begin
                w_dstart = 1'b1;
                w_dden   = w_s[DW-1:0];
            end
            ST_U1: begin
                w_dstart = w_dstat.done;
                w_dnum   = r_c10;
            end
            ST_U2: begin
                w_mstart = w_dstat.done;
                w_ma     = r_k0;
                w_mb     = r_y;
            end
            ST_U3: begin
                w_mstart = w_mstat.done;
                w_ma     = r_k1;
                w_mb     = r_y;
            end
            ST_U4: begin
                w_mstart = w_mstat.done;
                w_ma     = r_k0;
                w_mb     = r_c00;
            end
            ST_U5: begin
                w_mstart = w_mstat.done;
                w_ma     = r_k0;
                w_mb     = r_c01;
            end
            ST_U6: begin
                w_mstart = w_mstat.done;
                w_ma     = r_k1;
                w_mb     = r_c00;
            end
            ST_U7: begin
                w_mstart = w_mstat.done;
                w_ma     = r_k1;
                w_mb     = r_c01;
            end
            default: ;
        endcase
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_angle <= '0;
            r_bias  <= '0;
            r_c00   <= '0;
            r_c01   <= '0;
            r_c10   <= '0;
            r_c11   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_P1: if (w_mstat.done) r_angle <= w_ang[DW-1:0];
                ST_P5: begin
                    if (w_mstat.done) begin
                        r_c00 <= w_n00[DW-1:0];
                        r_c01 <= w_c01[DW-1:0];
                        r_c10 <= w_c10[DW-1:0];
                        r_c11 <= w_n11[DW-1:0];
                    end
                end
                ST_U3: if (w_mstat.done) r_angle <= w_ang[DW-1:0];
                ST_U4: if (w_mstat.done) r_bias <= w_bia[DW-1:0];
                ST_U7: if (w_mstat.done) r_c10 <= w_c10[DW-1:0];
                ST_U8: begin
                    if (w_mstat.done) begin
                        r_c11 <= w_c11[DW-1:0];
                        r_c00 <= r_t;
                        r_c01 <= r_u;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers and the step's saturation flag
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_rate <= i_q_rate;
                    r_ts   <= i_q_tstep;
                    r_meas <= i_q_meas;
                    r_sat  <= 1'b0;
                end
            end
            ST_P0: begin
                r_dt  <= w_dt[DW-1:0];
                r_sat <= r_sat | w_dt[DW] | w_opd[DW];
            end
            ST_P1: if (w_mstat.done) r_sat <= r_sat | w_mstat.sat | w_ang[DW] | w_sum[DW];
            ST_P2: begin
                if (w_mstat.done) begin
                    r_t   <= w_t[DW-1:0];
                    r_sat <= r_sat | w_mstat.sat | w_t[DW];
                end
            end
            ST_P3: if (w_mstat.done) r_sat <= r_sat | w_mstat.sat;
            ST_P4: begin
                if (w_mstat.done) begin
                    r_u   <= w_u[DW-1:0];
                    r_sat <= r_sat | w_mstat.sat | w_u[DW];
                end
            end
            ST_P5: begin
                if (w_mstat.done) begin
                    r_sat <= r_sat | w_mstat.sat | w_n00[DW] | w_c01[DW] | w_c10[DW]
                             | w_n11[DW];
                end
            end
            ST_U0: begin
                r_s   <= w_s[DW-1:0];
                r_y   <= w_y[DW-1:0];
                r_sat <= r_sat | w_s[DW] | w_y[DW];
            end
            ST_U1: begin
                if (w_dstat.done) begin
                    r_k0  <= w_dres;
                    r_sat <= r_sat | w_dstat.sat;
                end
            end
            ST_U2: begin
                if (w_dstat.done) begin
                    r_k1  <= w_dres;
                    r_sat <= r_sat | w_dstat.sat;
                end
            end
            ST_U3: if (w_mstat.done) r_sat <= r_sat | w_mstat.sat | w_ang[DW];
            ST_U4: if (w_mstat.done) r_sat <= r_sat | w_mstat.sat | w_bia[DW];
            ST_U5: begin
                if (w_mstat.done) begin
                    r_t   <= w_t[DW-1:0];
                    r_sat <= r_sat | w_mstat.sat | w_t[DW];
                end
            end
            ST_U6: begin
                if (w_mstat.done) begin
                    r_u   <= w_u01[DW-1:0];
                    r_sat <= r_sat | w_mstat.sat | w_u01[DW];
                end
            end
            ST_U7: if (w_mstat.done) r_sat <= r_sat | w_mstat.sat | w_c10[DW];
            ST_U8: if (w_mstat.done) r_sat <= r_sat | w_mstat.sat | w_c11[DW];
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && w_can_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && w_can_out) begin
            r_oang  <= r_angle;
            r_obias <= r_bias;
            r_osat  <= r_sat;
        end
    end

    assign o_valid          = r_ovalid;
    assign o_angle_estimate = r_oang;
    assign o_bias_estimate  = r_obias;
    assign o_saturated      = r_osat;

endmodule

>>> hw/rtl/angle_bias_kalman_filter.sv
// ---------------------------------------------------------------------------
// angle_bias_kalman_filter
// Two-state Kalman filter tracking angle and gyro bias in signed fixed point.
// ---------------------------------------------------------------------------
//  channel  handshake               contents
//  input    i_valid / o_stall       operation, gyro rate, time step, angle
//  result   o_valid / i_stall       angle and bias estimate, saturated flag
//  config   psel/penable/pwrite     three 47-bit noise registers at 8*i
//
//  a predict word runs five products on the shared multiplier; an update
//  word runs two quotients on the restoring divider, then six products
//  a two-word queue takes input while the back end works; a result waits in
//  its register and the next word runs until it needs that register
//  reset clears the filter state, the queue and the valid flag of the result register
// ---------------------------------------------------------------------------
module angle_bias_kalman_filter import abkf_pkg::*; #(
    parameter int DATA_WIDTH = 48,
    parameter int FRAC_BITS  = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_operation,
    input  logic signed [DATA_WIDTH-1:0] i_gyro_rate,
    input  logic [31:0]                  i_time_step,
    input  logic signed [DATA_WIDTH-1:0] i_measured_angle,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_angle_estimate,
    output logic signed [DATA_WIDTH-1:0] o_bias_estimate,
    output logic                         o_saturated,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [4:0]                   paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);

    logic [NOISE_W-1:0]           r_pna, r_pnb, r_mn;
    logic                         w_wr;
    logic                         w_qv, w_pop, w_qupd;
    logic signed [DATA_WIDTH-1:0] w_qrate, w_qmeas;
    logic [31:0]                  w_qts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // noise registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pna <= PNA_RESET;
            r_pnb <= PNB_RESET;
            r_mn  <= MN_RESET;
        end else if (w_wr) begin
            unique case (paddr[4:3])
                REG_PNA: r_pna <= pwdata[NOISE_W-1:0];
                REG_PNB: r_pnb <= pwdata[NOISE_W-1:0];
                REG_MN:  r_mn  <= pwdata[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (paddr[4:3])
            REG_PNA: prdata = 64'(r_pna);
            REG_PNB: prdata = 64'(r_pnb);
            REG_MN:  prdata = 64'(r_mn);
            default: prdata = '0;
        endcase
    end

    abkf_front #(.DW(DATA_WIDTH)) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_gyro_rate      (i_gyro_rate),
        .i_time_step      (i_time_step),
        .i_measured_angle (i_measured_angle),
        .o_q_valid        (w_qv),
        .i_pop            (w_pop),
        .o_q_update       (w_qupd),
        .o_q_rate         (w_qrate),
        .o_q_tstep        (w_qts),
        .o_q_meas         (w_qmeas)
    );

    abkf_back #(.DW(DATA_WIDTH), .FRAC(FRAC_BITS)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (w_qv),
        .o_q_pop          (w_pop),
        .i_q_update       (w_qupd),
        .i_q_rate         (w_qrate),
        .i_q_tstep        (w_qts),
        .i_q_meas         (w_qmeas),
        .i_pna            (r_pna),
        .i_pnb            (r_pnb),
        .i_mn             (r_mn),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_angle_estimate (o_angle_estimate),
        .o_bias_estimate  (o_bias_estimate),
        .o_saturated      (o_saturated)
    );

endmodule
